// ===== design/trilinear_devoxelize_gather_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the trilinear devoxelize gather unit
// Shared property wrappers. Each macro is clocked by clk_i and is disabled
// while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef TRILINEAR_DEVOXELIZE_GATHER_UNIT_ASSERT_SVH
`define TRILINEAR_DEVOXELIZE_GATHER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TDG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tdg assertion failed: same-cycle implication");

// Next-cycle implication.
`define TDG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tdg assertion failed: next-cycle implication");

`endif

// ===== design/tdg_pkg.sv =====
// ---------------------------------------------------------------------------
// tdg_pkg
// Shared constants of the trilinear devoxelize gather unit.
// ---------------------------------------------------------------------------
package tdg_pkg;

  localparam int VoxelsDefault   = 4096;
  localparam int ChannelsDefault = 16;
  localparam int Corners         = 8;

  localparam int FeatW  = 16;
  localparam int WgtW   = 17;
  localparam int AccW   = 36;
  localparam int ProdW  = WgtW + 1 + FeatW;
  localparam int CfgW   = 5;
  localparam int OutChW = 4;

  localparam logic [CfgW-1:0] CfgReset = 5'd16;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpCorner = 1'b1;

endpackage

// ===== design/tdg_ram.sv =====
// ---------------------------------------------------------------------------
// tdg_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module tdg_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/trilinear_devoxelize_gather_unit.sv =====
// ---------------------------------------------------------------------------
// trilinear_devoxelize_gather_unit
// Gathers the features of the eight corner voxels around a point and blends
// them with per-corner weights into one interpolated feature per channel.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  s_axis    in         tuser = operation; tdata = load_voxel, load_channel,
//                       feature_value, corner_voxel, corner_weight
//  m_axis    out        tuser = out_channel; tdata = out_value; tlast = out_last
//  cfg       in         cfg_data = channels_in_use
//
// A load transaction writes the feature word into the feature store at the
// accepting edge. In a corner transaction one shared multiplier and one
// accumulator adder work through the n channels in use, one channel per
// cycle, behind the registered read port of the feature store. An empty
// corner issues no reads. After the eighth corner the n results follow,
// one result per cycle while the output side takes them. The output register
// decouples the sides, so a new transaction may be accepted while the last
// result still waits. Reset clears the accumulators, the corner count and
// the channel register (to 16); the feature store needs no clearing pass.
//
module trilinear_devoxelize_gather_unit #(
  parameter int VOXELS   = tdg_pkg::VoxelsDefault,
  parameter int CHANNELS = tdg_pkg::ChannelsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  // Feature loads and weighted corners.
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [11:0] load_voxel, [15:12] load_channel, [31:16] feature_value,
  // [44:32] corner_voxel, [61:45] corner_weight, [63:62] zero
  input  logic [63:0]              s_axis_tdata_i,
  // [0] operation
  input  logic                     s_axis_tuser_i,

  // Interpolated features, one per channel in use.
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // [15:0] out_value
  output logic [15:0]              m_axis_tdata_o,
  // [3:0] out_channel
  output logic [3:0]               m_axis_tuser_o,
  output logic                     m_axis_tlast_o,

  // channels_in_use register.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [tdg_pkg::CfgW-1:0] cfg_data_i
);

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int VW    = $clog2(VOXELS);
  localparam int NW    = $clog2(CHANNELS + 1);
  localparam int AW    = VW + CW;
  localparam int Depth = VOXELS << CW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMac  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  // Saturating scale: floor shift by 16, then clamp to signed 16 bits.
  function automatic logic [tdg_pkg::FeatW-1:0] scale_sat(
    input logic [tdg_pkg::AccW-1:0] a
  );
    logic [tdg_pkg::FeatW-1:0] r;
    if (a[35:31] == 5'b00000 || a[35:31] == 5'b11111) begin
      r = a[31:16];
    end else if (a[35]) begin
      r = 16'h8000;
    end else begin
      r = 16'h7FFF;
    end
    return r;
  endfunction

  // Field decode.
  logic        op;
  logic [11:0] load_voxel;
  logic [3:0]  load_channel;
  logic [15:0] feature_value;
  logic [12:0] corner_voxel;
  logic [16:0] corner_weight;

  assign op            = s_axis_tuser_i;
  assign load_voxel    = s_axis_tdata_i[11:0];
  assign load_channel  = s_axis_tdata_i[15:12];
  assign feature_value = s_axis_tdata_i[31:16];
  assign corner_voxel  = s_axis_tdata_i[44:32];
  assign corner_weight = s_axis_tdata_i[61:45];

  logic [1:0]               state_q, state_d;
  logic [tdg_pkg::CfgW-1:0] cfg_q;
  logic [2:0]               corner_cnt_q;
  logic [VW-1:0]            vox_q;
  logic [16:0]              wgt_q;
  logic [NW-1:0]            n_q;
  logic                     final_q;
  logic [NW-1:0]            iss_q;
  logic                     rd_vld_q;
  logic [CW-1:0]            rd_ch_q;
  logic                     mul_vld_q;
  logic [CW-1:0]            mul_ch_q;
  logic signed [tdg_pkg::ProdW-1:0] prod_q;
  logic [tdg_pkg::AccW-1:0] acc_q [CHANNELS];
  logic [NW-1:0]            emit_cnt_q;
  logic                     out_vld_q;
  logic [15:0]              out_val_q;
  logic [3:0]               out_ch_q;
  logic                     out_last_q;

  logic          in_acc;
  logic          corner_acc;
  logic [NW-1:0] n_active;
  logic          corner_ok;
  logic          load_ok;
  logic [31:0]   lvox32, lch32, cvox32, iss32;
  logic          issue;
  logic          mac_done;
  logic          out_load;
  logic          emit_last;
  logic [15:0]   ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic          ram_we;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == StIdle);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign corner_acc      = in_acc && (op == tdg_pkg::OpCorner);

  // A count of zero acts as one, and a count above CHANNELS as CHANNELS.
  always_comb begin
    if (cfg_q == '0) begin
      n_active = NW'(1);
    end else if (32'(cfg_q) > CHANNELS) begin
      n_active = NW'(CHANNELS);
    end else begin
      n_active = NW'(cfg_q);
    end
  end

  assign lvox32    = 32'(load_voxel);
  assign lch32     = 32'(load_channel);
  assign cvox32    = 32'(corner_voxel[11:0]);
  assign iss32     = 32'(iss_q);
  assign load_ok   = (lvox32 < VOXELS) && (lch32 < CHANNELS);
  assign corner_ok = !corner_voxel[12] && (cvox32 < VOXELS);

  assign ram_we    = in_acc && (op == tdg_pkg::OpLoad) && load_ok;
  assign ram_waddr = {lvox32[VW-1:0], lch32[CW-1:0]};
  assign issue     = (state_q == StMac) && (iss_q < n_q);
  assign ram_raddr = {vox_q, iss32[CW-1:0]};
  assign mac_done  = (state_q == StMac) && !issue && !rd_vld_q && !mul_vld_q;

  assign out_load  = (state_q == StEmit) && (!out_vld_q || m_axis_tready_i);
  assign emit_last = (emit_cnt_q == n_q - NW'(1));

  tdg_ram #(
    .Width (tdg_pkg::FeatW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (feature_value),
    .re_i    (issue),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (corner_acc) begin
          state_d = StMac;
        end
      end
      StMac: begin
        if (mac_done) begin
          state_d = final_q ? StEmit : StIdle;
        end
      end
      StEmit: begin
        if (out_load && emit_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cfg_q        <= tdg_pkg::CfgReset;
      corner_cnt_q <= '0;
      iss_q        <= '0;
      rd_vld_q     <= 1'b0;
      mul_vld_q    <= 1'b0;
      emit_cnt_q   <= '0;
      out_vld_q    <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        acc_q[c] <= '0;
      end
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      mul_vld_q <= rd_vld_q;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      if (corner_acc) begin
        corner_cnt_q <= corner_cnt_q + 3'd1;
        // An empty corner issues no reads at all.
        iss_q        <= corner_ok ? '0 : n_active;
      end else if (issue) begin
        iss_q <= iss_q + NW'(1);
      end
      if (mul_vld_q) begin
        acc_q[mul_ch_q] <= acc_q[mul_ch_q] + tdg_pkg::AccW'(prod_q);
      end
      if (mac_done) begin
        emit_cnt_q <= '0;
      end else if (out_load) begin
        emit_cnt_q <= emit_cnt_q + NW'(1);
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      // Every accumulator is cleared once the last result has left them.
      if (out_load && emit_last) begin
        for (int c = 0; c < CHANNELS; c++) begin
          acc_q[c] <= '0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (corner_acc) begin
      vox_q   <= cvox32[VW-1:0];
      wgt_q   <= corner_weight;
      n_q     <= n_active;
      final_q <= (corner_cnt_q == 3'(tdg_pkg::Corners - 1));
    end
    rd_ch_q  <= iss32[CW-1:0];
    mul_ch_q <= rd_ch_q;
    if (rd_vld_q) begin
      prod_q <= $signed({1'b0, wgt_q}) * $signed(ram_rdata);
    end
    if (out_load) begin
      out_val_q  <= scale_sat(acc_q[emit_cnt_q[CW-1:0]]);
      out_ch_q   <= 4'(emit_cnt_q);
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_val_q;
  assign m_axis_tuser_o  = out_ch_q;
  assign m_axis_tlast_o  = out_last_q;

`include "trilinear_devoxelize_gather_unit_assert.svh"

  // The multiply pipeline is drained whenever new work may be accepted.
  `TDG_ASSERT_IMPL(a_idle_pipe_empty, state_q == StIdle, !rd_vld_q && !mul_vld_q)
  // The eighth corner always leads to accumulation work, never straight back.
  `TDG_ASSERT_NEXT(a_final_corner_busy, corner_acc && corner_cnt_q == 3'd7, state_q == StMac)
  // After the last result is loaded the accumulator of channel 0 is clear.
  `TDG_ASSERT_NEXT(a_acc_cleared, out_load && emit_last, acc_q[0] == '0)
  // Results are only produced while emitting.
  `TDG_ASSERT_IMPL(a_emit_only, out_load, state_q == StEmit && corner_cnt_q == 3'd0)

endmodule
